>>> rtl/msms_pkg.sv
// shared types and constants for the min/max/sum stack
package msms_pkg;

   localparam int DEPTH    = 256;
   localparam int DATA_W   = 32;
   localparam int TOTAL_W  = 40;
   localparam int ENTRY_W  = 9;
   localparam int COUNT_W  = $clog2(DEPTH + 1);
   localparam int MODE_W   = 2;
   localparam int ERROR_W  = 2;

   localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   localparam logic [ERROR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERROR_W-1:0] ERR_FULL  = 2'd1;
   localparam logic [ERROR_W-1:0] ERR_EMPTY = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] max_val;
      logic signed [DATA_W-1:0] min_val;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } shift_type;

   typedef struct packed {
      logic [COUNT_W-1:0]        count;
      logic signed [TOTAL_W-1:0] total;
      logic [ERROR_W-1:0]        error;
   } status_type;

endpackage

>>> rtl/stack_with_min_max_sum.sv
// top level of the min/max/sum stack: control plus a chain of entry cells
//
// Each request word carries a mode (push, pop, clear) and a value; each
// accepted request produces exactly one response word with the top value,
// the running sum, the largest and smallest held values, the entry count,
// an empty flag and an error code (full on push, empty on pop).
// A request is taken on a clock edge where req_valid is high and req_stall
// low; a response is taken where rsp_valid is high and rsp_stall low.
// The response is valid in the cycle after the request is taken. One request
// per cycle is sustained while the receiver does not stall; the entries sit in
// a row of cells that all shift down on a push and up on a pop in the same
// cycle, so the top entry and its neighbor are always in registers.
// When the receiver stalls, the response holds and req_stall rises, so at
// most one response waits at a time.
// Synchronous reset empties the stack (count and sum to zero) at once and
// drops any pending response; entry contents are left as they are.
module stack_with_min_max_sum (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [msms_pkg::MODE_W-1:0]         req_mode,
   input  logic signed [msms_pkg::DATA_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [msms_pkg::DATA_W-1:0]  rsp_top_value,
   output logic signed [msms_pkg::TOTAL_W-1:0] rsp_total,
   output logic signed [msms_pkg::DATA_W-1:0]  rsp_largest,
   output logic signed [msms_pkg::DATA_W-1:0]  rsp_smallest,
   output logic [msms_pkg::ENTRY_W-1:0]        rsp_entry_total,
   output logic                                rsp_is_empty,
   output logic [msms_pkg::ERROR_W-1:0]        rsp_error
);
   import msms_pkg::*;

   entry_type  cells [DEPTH];
   entry_type  new_entry;
   shift_type  ctl;
   status_type status;
   logic       empty;

   msms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .top_entry (cells[0]),
      .new_entry (new_entry),
      .ctl       (ctl),
      .status    (status)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type above, below;
      if (i == 0) begin : g_head
         assign above = new_entry;
      end else begin : g_mid
         assign above = cells[i-1];
      end
      // the bottom cell pulls in zeros on pop; it is never read before a push
      if (i == DEPTH - 1) begin : g_tail
         assign below = '0;
      end else begin : g_body
         assign below = cells[i+1];
      end
      msms_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .from_above (above),
         .from_below (below),
         .entry      (cells[i])
      );
   end

   // state only moves on an accepted request, which a stalled response blocks
   assign empty           = (status.count == '0);
   assign rsp_top_value   = empty ? '0 : cells[0].value;
   assign rsp_largest     = empty ? '0 : cells[0].max_val;
   assign rsp_smallest    = empty ? '0 : cells[0].min_val;
   assign rsp_total       = empty ? '0 : status.total;
   assign rsp_entry_total = ENTRY_W'(status.count);
   assign rsp_is_empty    = empty;
   assign rsp_error       = status.error;

endmodule

>>> rtl/msms_cell.sv
// one stack entry: shifts down on push, up on pop
module msms_cell (
   input  logic                clock,
   input  msms_pkg::shift_type ctl,
   input  msms_pkg::entry_type from_above,
   input  msms_pkg::entry_type from_below,
   output msms_pkg::entry_type entry
);
   import msms_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.push) begin
         entry_in = from_above;
      end else if (ctl.pop) begin
         entry_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

>>> rtl/msms_ctrl.sv
// handshake, entry count, running total and the new top entry
module msms_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [msms_pkg::MODE_W-1:0]     req_mode,
   input  logic signed [msms_pkg::DATA_W-1:0] req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  msms_pkg::entry_type             top_entry,
   output msms_pkg::entry_type             new_entry,
   output msms_pkg::shift_type             ctl,
   output msms_pkg::status_type            status
);
   import msms_pkg::*;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic signed [TOTAL_W-1:0] total_ff, total_in;
   logic [ERROR_W-1:0]        error_ff, error_in;
   logic                      req_fire, empty, full;

   // a new word only enters once the pending result is free to move
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == COUNT_FULL);

   always_comb begin
      new_entry.value   = req_value;
      new_entry.max_val = req_value;
      new_entry.min_val = req_value;
      if (!empty && top_entry.max_val > req_value) new_entry.max_val = top_entry.max_val;
      if (!empty && top_entry.min_val < req_value) new_entry.min_val = top_entry.min_val;
   end

   always_comb begin
      ctl.push = 1'b0;
      ctl.pop  = 1'b0;
      count_in = count_ff;
      total_in = total_ff;
      error_in = error_ff;
      if (req_fire) begin
         error_in = ERR_OK;
         unique case (req_mode)
            MODE_PUSH: begin
               if (full) begin
                  error_in = ERR_FULL;
               end else begin
                  ctl.push = 1'b1;
                  count_in = count_ff + 1'b1;
                  total_in = total_ff
                           + {{(TOTAL_W-DATA_W){req_value[DATA_W-1]}}, req_value};
               end
            end
            MODE_POP: begin
               if (empty) begin
                  error_in = ERR_EMPTY;
               end else begin
                  ctl.pop  = 1'b1;
                  count_in = count_ff - 1'b1;
                  total_in = total_ff
                           - {{(TOTAL_W-DATA_W){top_entry.value[DATA_W-1]}},
                              top_entry.value};
               end
            end
            MODE_CLEAR: begin
               count_in = '0;
               total_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         total_ff     <= '0;
         error_ff     <= ERR_OK;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         error_ff     <= error_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign status.count  = count_ff;
   assign status.total  = total_ff;
   assign status.error  = error_ff;

`ifndef NO_ASSERTIONS
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_mode == MODE_PUSH && !full)
      |=> count_ff == COUNT_W'($past(count_ff) + 1'b1))
      else $error("push did not grow the stack");

   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with no pending result");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && error_ff == ERR_FULL) |-> full)
      else $error("full error while stack not full");

   a_empty_total: assert property (@(posedge clock) disable iff (reset)
      empty |-> total_ff == '0)
      else $error("nonzero total on empty stack");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> count_ff <= COUNT_FULL)
      else $error("entry count beyond depth");
`endif

endmodule
